### src/efws_pkg.sv
// ----------------------------------------------------------------------------
// efws_pkg
// Shared types and constants of the earliest-finish worker select block:
// request and response beats, configuration, the scan token and write-back.
// ----------------------------------------------------------------------------
package efws_pkg;

  // fixed field widths
  localparam int TIME_W    = 32;
  localparam int NUM_TYPES = 4;
  localparam int TYPE_W    = 2;
  localparam int MAP_W     = 16;
  localparam int WORKER_W  = 3;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  // worker index inside the cell row, wide enough for 64 workers
  localparam int IDX_W     = 6;

  // request kinds
  localparam logic ACT_MAP = 1'b0;
  localparam logic ACT_SET = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WORKERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MAP       = 1'b1;

  localparam logic [COUNT_W-1:0] ACTIVE_RESET = 4'd8;

  typedef struct packed {
    logic                action;
    logic [TIME_W-1:0]   earliest_start;
    logic [NUM_TYPES-1:0] allowed_types;
    logic [TIME_W-1:0]   exec_time_type0;
    logic [TIME_W-1:0]   exec_time_type1;
    logic [TIME_W-1:0]   exec_time_type2;
    logic [TIME_W-1:0]   exec_time_type3;
    logic [WORKER_W-1:0] target_worker;
    logic [TIME_W-1:0]   new_ready_time;
  } req_beat_t;

  typedef struct packed {
    logic [WORKER_W-1:0] chosen_worker;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   finish_time;
    logic                no_worker;
  } rsp_beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] active_workers;
    logic [MAP_W-1:0]   worker_type_map;
  } cfg_t;

  // running best, handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] wait_time;
  } token_t;

  // ready time update broadcast to the row
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] data;
  } wr_t;

endpackage

### src/earliest_finish_worker_select_core.sv
// ----------------------------------------------------------------------------
// earliest_finish_worker_select_core
// Picks the worker that finishes a task earliest and books it, or sets a worker's ready time.
// ----------------------------------------------------------------------------
// Requests come in on req (req_valid / req_stall), one response per request
// leaves on rsp (rsp_valid / rsp_stall). A beat moves when valid is high and
// stall is low. cfg_we writes active_workers (index 0) or worker_type_map
// (index 1) from cfg_data. The user must write them only while no request is
// in flight; the block does not enforce it.
// A map request loads a request register, each worker cell registers its own
// candidate, then a token walks the row of NUM_WORKERS cells one cell per
// cycle. At the end of the scan the result is written back and registered. A
// set request writes the ready time at once; its response passes through the
// holding register into the response register. One request is in flight at a
// time; req_stall is high meanwhile.
// The response register holds its beat while rsp_stall is high; a finished
// result waits in a holding register and the scan of the next request does
// not begin until that result has moved on.
// Synchronous reset clears all ready times to zero, active_workers to 8 and
// worker_type_map to 0, and empties the response register.
// ----------------------------------------------------------------------------
module earliest_finish_worker_select_core #(
  parameter int NUM_WORKERS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [efws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [efws_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  efws_pkg::req_beat_t                 req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output efws_pkg::rsp_beat_t                 rsp
);

  localparam int CNT_W = $clog2(NUM_WORKERS + 2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt;
  efws_pkg::req_beat_t req_q;
  efws_pkg::cfg_t      cfg;
  efws_pkg::rsp_beat_t res;
  efws_pkg::rsp_beat_t res_next;
  efws_pkg::wr_t       wr;
  efws_pkg::token_t    tok [0:NUM_WORKERS];
  efws_pkg::token_t    best;
  logic                accept;
  logic                scan_end;
  logic                out_free;
  logic                load_rsp;
  logic                target_ok;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign scan_end  = (state == ST_SCAN) && (cnt == CNT_W'(NUM_WORKERS + 1));
  assign best      = tok[NUM_WORKERS];
  assign target_ok = ({4'b0000, req.target_worker} < 7'(NUM_WORKERS));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_workers  <= efws_pkg::ACTIVE_RESET;
      cfg.worker_type_map <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efws_pkg::REG_ACTIVE_WORKERS: cfg.active_workers <= cfg_data[efws_pkg::COUNT_W-1:0];
        efws_pkg::REG_TYPE_MAP:       cfg.worker_type_map <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register, stable for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // result of a finished scan
  always_comb begin
    res_next = '0;
    if (best.found) begin
      res_next.chosen_worker = best.idx[efws_pkg::WORKER_W-1:0];
      res_next.start_time    = best.start_time;
      res_next.finish_time   = best.finish_time;
      res_next.no_worker     = 1'b0;
    end else begin
      res_next.no_worker     = 1'b1;
    end
  end

  // ready time write-back: set request at its beat, map at end of scan
  always_comb begin
    wr = '0;
    if (accept && (req.action == efws_pkg::ACT_SET)) begin
      wr.en   = target_ok;
      wr.idx  = efws_pkg::IDX_W'(req.target_worker);
      wr.data = req.new_ready_time;
    end else if (scan_end) begin
      wr.en   = best.found;
      wr.idx  = best.idx;
      wr.data = best.finish_time;
    end
  end

  // row of worker cells
  assign tok[0] = '0;
  generate
    for (genvar i = 0; i < NUM_WORKERS; i++) begin : g_cell
      efws_cell #(
        .IDX(i)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .req    (req_q),
        .cfg    (cfg),
        .wr     (wr),
        .tok_in (tok[i]),
        .tok_out(tok[i + 1])
      );
    end
  endgenerate

  // sequencer
  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.action == efws_pkg::ACT_SET) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          load_rsp   = out_free;
          state_next = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_SCAN) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // holding register for a result waiting on the output
  always_ff @(posedge clk) begin
    if (accept && (req.action == efws_pkg::ACT_SET)) begin
      res.chosen_worker <= req.target_worker;
      res.start_time    <= '0;
      res.finish_time   <= req.new_ready_time;
      res.no_worker     <= !target_ok;
    end else if (scan_end) begin
      res <= res_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= (state == ST_SCAN) ? res_next : res;
    end
  end

endmodule

### src/efws_cell.sv
// ----------------------------------------------------------------------------
// efws_cell
// One worker: holds its ready time, works out its candidate start and finish
// for the current request and folds them into the token passing by.
// ----------------------------------------------------------------------------
module efws_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  efws_pkg::req_beat_t req,
  input  efws_pkg::cfg_t    cfg,
  input  efws_pkg::wr_t     wr,
  input  efws_pkg::token_t  tok_in,
  output efws_pkg::token_t  tok_out
);

  logic [efws_pkg::TIME_W-1:0] ready;
  logic [efws_pkg::TYPE_W-1:0] ctype;
  logic [efws_pkg::NUM_TYPES-1:0][efws_pkg::TIME_W-1:0] exec;
  logic                        eligible;
  logic [efws_pkg::TIME_W-1:0] start_c;
  logic [efws_pkg::TIME_W:0]   sum_c;
  logic [efws_pkg::TIME_W-1:0] finish_c;
  logic [efws_pkg::TIME_W-1:0] wait_c;
  logic                        cand_ok;
  logic [efws_pkg::TIME_W-1:0] cand_start;
  logic [efws_pkg::TIME_W-1:0] cand_finish;
  logic [efws_pkg::TIME_W-1:0] cand_wait;
  logic                        take;

  // worker type from the map, type 0 beyond it
  generate
    if (IDX * efws_pkg::TYPE_W + efws_pkg::TYPE_W <= efws_pkg::MAP_W) begin : g_mapped
      assign ctype = cfg.worker_type_map[IDX * efws_pkg::TYPE_W +: efws_pkg::TYPE_W];
    end else begin : g_unmapped
      assign ctype = '0;
    end
  endgenerate

  assign exec[0] = req.exec_time_type0;
  assign exec[1] = req.exec_time_type1;
  assign exec[2] = req.exec_time_type2;
  assign exec[3] = req.exec_time_type3;

  // active and of an allowed type
  assign eligible = (7'(IDX) < {3'b000, cfg.active_workers}) && req.allowed_types[ctype];

  // candidate start, saturating finish and wait
  always_comb begin
    start_c  = (req.earliest_start > ready) ? req.earliest_start : ready;
    sum_c    = {1'b0, start_c} + {1'b0, exec[ctype]};
    finish_c = sum_c[efws_pkg::TIME_W] ? '1 : sum_c[efws_pkg::TIME_W-1:0];
    wait_c   = start_c - ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_ok <= 1'b0;
    end else begin
      cand_ok <= eligible;
    end
    cand_start  <= start_c;
    cand_finish <= finish_c;
    cand_wait   <= wait_c;
  end

  // least finish, then least wait; ties keep the earlier worker
  assign take = cand_ok && (!tok_in.found || (cand_finish < tok_in.finish_time) ||
                ((cand_finish == tok_in.finish_time) && (cand_wait < tok_in.wait_time)));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (take) begin
      tok_out.found       <= 1'b1;
      tok_out.idx         <= efws_pkg::IDX_W'(IDX);
      tok_out.start_time  <= cand_start;
      tok_out.finish_time <= cand_finish;
      tok_out.wait_time   <= cand_wait;
    end else begin
      tok_out <= tok_in;
    end
  end

  // ready time write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
    end else if (wr.en && (wr.idx == efws_pkg::IDX_W'(IDX))) begin
      ready <= wr.data;
    end
  end

endmodule

### src/efws_checker.sv
// ----------------------------------------------------------------------------
// efws_checker
// Port-level checks on the earliest-finish worker select block.
// ----------------------------------------------------------------------------
module efws_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input efws_pkg::rsp_beat_t             rsp
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // one request in flight: stall follows every request beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in flight");

  // a task never finishes before it starts
  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.no_worker |-> rsp.finish_time >= rsp.start_time)
    else $error("finish time before start time");

  // nothing scheduled means no start time
  a_no_worker_start: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.no_worker |-> rsp.start_time == '0)
    else $error("start time reported without a worker");

endmodule

bind earliest_finish_worker_select_core efws_checker u_efws_checker (.*);
